/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* src/wwsc_pkg.sv */
// ----------------------------------------------------------------------------
// wwsc_pkg
// shared types, constants and helpers of the whole-word substring counter
// ----------------------------------------------------------------------------
package wwsc_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int BYTE_W          = 8;
	localparam int POS_W           = 32;
	localparam int CNT_W           = 31;
	localparam int REG_W           = 64;
	localparam int LEN_W           = 5;
	localparam int IDX_W           = 2;
	localparam int NREC            = 3;
	localparam int QUEUE_DEPTH     = 4;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
	localparam logic [IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
	localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;
	localparam logic [IDX_W-1:0] REG_WHOLE_WORDS    = 2'd3;

	localparam logic [CNT_W-1:0] COUNT_MAX     = '1;
	localparam logic [POS_W-1:0] QUARTER_RANGE = 32'h4000_0000;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] count;
		logic             summary;
	} rec_t;

	// records caused by one text byte: pending match, new match, summary
	typedef struct packed {
		logic [NREC-1:0] valid;
		rec_t [NREC-1:0] rec;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A)
			r = c + 8'd32;
		return r;
	endfunction

	function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

/* src/wwsc_front.sv */
// ----------------------------------------------------------------------------
// wwsc_front
// configuration registers, text window, match detection and decision logic
// ----------------------------------------------------------------------------
module wwsc_front #(
	parameter int PATTERN_MAX = wwsc_pkg::PATTERN_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [wwsc_pkg::IDX_W-1:0]    wr_index,
	input  logic [wwsc_pkg::REG_W-1:0]    wr_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [wwsc_pkg::BYTE_W-1:0]   s_tdata,   // text_byte
	input  logic                          s_tlast,   // last_byte
	input  logic                          q_full,
	output logic                          push,
	output wwsc_pkg::bundle_t             bundle
);

	localparam int WIN_DEPTH = PATTERN_MAX + 1;
	localparam int LW        = $clog2(PATTERN_MAX + 1);
	localparam int FW        = $clog2(WIN_DEPTH + 1);
	localparam int PW        = wwsc_pkg::POS_W;
	localparam int CW        = wwsc_pkg::CNT_W;
	localparam int BW        = wwsc_pkg::BYTE_W;

	logic [wwsc_pkg::REG_W-1:0] pat_lo_q, pat_hi_q;
	logic [wwsc_pkg::LEN_W-1:0] plen_cfg_q;
	logic                       whole_q;

	logic [BW-1:0] win_q [WIN_DEPTH];
	logic [BW-1:0] win_n [WIN_DEPTH];
	logic [FW-1:0] fill_q, fill_n;
	logic [PW-1:0] idx_q, nas_q, ps_q, first_q;
	logic [CW-1:0] cnt_q;
	logic          pend_q, any_q;

	logic [2*wwsc_pkg::REG_W-1:0] pat_all;
	logic [BW-1:0]                pat_f [PATTERN_MAX];
	logic [LW-1:0]                plen;
	logic [PATTERN_MAX:0]         len_hit;
	logic [WIN_DEPTH-1:0]         alnum_tap;
	logic                         fire, len_nz, enough;
	logic                         acc0, acc1, cand, ok, pend_n;
	logic [PW-1:0]                nas1, nas2, nas3, s, d, d2, first1, first2;
	logic [CW-1:0]                cnt1, cnt2;
	logic                         any1, any2;

	assign fire     = s_tvalid && s_tready;
	assign s_tready = !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q   <= '0;
			pat_hi_q   <= '0;
			plen_cfg_q <= '0;
			whole_q    <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				wwsc_pkg::REG_PATTERN_LOW:    pat_lo_q   <= wr_data;
				wwsc_pkg::REG_PATTERN_HIGH:   pat_hi_q   <= wr_data;
				wwsc_pkg::REG_PATTERN_LENGTH: plen_cfg_q <= wr_data[wwsc_pkg::LEN_W-1:0];
				wwsc_pkg::REG_WHOLE_WORDS:    whole_q    <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign pat_all = {pat_hi_q, pat_lo_q};

	always_comb begin
		for (int j = 0; j < PATTERN_MAX; j++)
			pat_f[j] = wwsc_pkg::fold_byte(pat_all[BW*j +: BW]);
	end

	// over-long length acts as the maximum
	assign plen = (plen_cfg_q > wwsc_pkg::LEN_W'(PATTERN_MAX)) ? LW'(PATTERN_MAX)
		: LW'(plen_cfg_q);
	assign len_nz = (plen != '0);

	always_comb begin
		win_n[0] = wwsc_pkg::fold_byte(s_tdata);
		for (int k = 1; k < WIN_DEPTH; k++)
			win_n[k] = win_q[k-1];
	end

	always_comb begin
		for (int k = 0; k < WIN_DEPTH; k++)
			alnum_tap[k] = wwsc_pkg::is_alnum(win_n[k]);
	end

	// one comparator row per candidate length, fixed taps
	always_comb begin
		logic hit;
		len_hit[0] = 1'b0;
		for (int l = 1; l <= PATTERN_MAX; l++) begin
			hit = 1'b1;
			for (int j = 0; j < PATTERN_MAX; j++)
				if (j < l)
					hit = hit & (win_n[l-1-j] == pat_f[j]);
			len_hit[l] = hit;
		end
	end

	assign fill_n = (fill_q == FW'(WIN_DEPTH)) ? fill_q : fill_q + FW'(1);
	assign enough = (fill_n >= FW'(plen));

	// pending candidate decided by the byte after it
	assign acc0   = pend_q && len_nz && (!whole_q || !alnum_tap[0]);
	assign nas1   = acc0 ? ps_q + PW'(plen) : nas_q;
	assign cnt1   = (acc0 && cnt_q != wwsc_pkg::COUNT_MAX) ? cnt_q + CW'(1) : cnt_q;
	assign any1   = any_q || acc0;
	assign first1 = (acc0 && !any_q) ? ps_q : first_q;

	// candidate ending at this byte
	assign s    = idx_q - PW'(plen) + PW'(1);
	assign d    = s - nas1;
	assign cand = len_nz && enough && len_hit[plen] && !d[PW-1];
	assign ok   = !whole_q || (d == '0) || (fill_n <= FW'(plen)) || !alnum_tap[plen];
	assign acc1   = cand && ok && (!whole_q || s_tlast);
	assign pend_n = cand && ok && whole_q && !s_tlast;

	assign nas2   = acc1 ? s + PW'(plen) : nas1;
	assign cnt2   = (acc1 && cnt1 != wwsc_pkg::COUNT_MAX) ? cnt1 + CW'(1) : cnt1;
	assign any2   = any1 || acc1;
	assign first2 = (acc1 && !any1) ? s : first1;

	// keep the start limit within a quarter range behind the index
	assign d2   = idx_q - nas2;
	assign nas3 = (d2[PW-1:PW-2] == 2'b01) ? idx_q - wwsc_pkg::QUARTER_RANGE : nas2;

	always_comb begin
		bundle.valid         = {s_tlast, acc1, acc0};
		bundle.rec[0].found   = 1'b1;
		bundle.rec[0].pos     = ps_q;
		bundle.rec[0].count   = cnt1;
		bundle.rec[0].summary = 1'b0;
		bundle.rec[1].found   = 1'b1;
		bundle.rec[1].pos     = s;
		bundle.rec[1].count   = cnt2;
		bundle.rec[1].summary = 1'b0;
		bundle.rec[2].found   = any2;
		bundle.rec[2].pos     = any2 ? first2 : '0;
		bundle.rec[2].count   = cnt2;
		bundle.rec[2].summary = 1'b1;
	end

	assign push = fire && (bundle.valid != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_DEPTH; k++)
				win_q[k] <= '0;
			fill_q  <= '0;
			idx_q   <= '0;
			nas_q   <= '0;
			pend_q  <= 1'b0;
			ps_q    <= '0;
			cnt_q   <= '0;
			first_q <= '0;
			any_q   <= 1'b0;
		end else if (fire) begin
			if (s_tlast) begin
				// end of text: back to a fresh stream
				for (int k = 0; k < WIN_DEPTH; k++)
					win_q[k] <= '0;
				fill_q  <= '0;
				idx_q   <= '0;
				nas_q   <= '0;
				pend_q  <= 1'b0;
				ps_q    <= '0;
				cnt_q   <= '0;
				first_q <= '0;
				any_q   <= 1'b0;
			end else begin
				for (int k = 0; k < WIN_DEPTH; k++)
					win_q[k] <= win_n[k];
				fill_q  <= fill_n;
				idx_q   <= idx_q + PW'(1);
				nas_q   <= nas3;
				pend_q  <= pend_n;
				if (pend_n)
					ps_q <= s;
				cnt_q   <= cnt2;
				first_q <= first2;
				any_q   <= any2;
			end
		end
	end

endmodule

/* src/wwsc_queue.sv */
// ----------------------------------------------------------------------------
// wwsc_queue
// short fifo of record bundles between the front and back parts
// ----------------------------------------------------------------------------
module wwsc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wwsc_pkg::bundle_t push_data,
	input  logic              pop,
	output wwsc_pkg::bundle_t head,
	output wwsc_pkg::q_stat_t stat
);

	localparam int DEPTH = wwsc_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	wwsc_pkg::bundle_t mem [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	// full, empty
	assign stat       = {(count_q == CNT_W'(DEPTH)), (count_q == '0)};
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (do_pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/wwsc_back.sv */
// ----------------------------------------------------------------------------
// wwsc_back
// holds one bundle and sends its records in order on the result stream
// ----------------------------------------------------------------------------
module wwsc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  wwsc_pkg::bundle_t head,
	input  logic              q_empty,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       m_tdata,   // match_found, match_position, match_count
	output logic              m_tuser    // is_summary
);

	localparam int NREC = wwsc_pkg::NREC;

	logic [NREC-1:0]           valid_q, valid_n;
	wwsc_pkg::rec_t [NREC-1:0] rec_q;
	wwsc_pkg::rec_t            sel;
	logic                      fire;

	always_comb begin
		priority if (valid_q[0])
			sel = rec_q[0];
		else if (valid_q[1])
			sel = rec_q[1];
		else
			sel = rec_q[2];
	end

	assign m_tvalid = (valid_q != '0);
	assign fire     = m_tvalid && m_tready;
	assign m_tdata  = {sel.count, sel.pos, sel.found};
	assign m_tuser  = sel.summary;

	// drop the lowest pending record after its transfer
	assign valid_n = fire ? (valid_q & (valid_q - NREC'(1))) : valid_q;
	assign pop     = (valid_n == '0) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (pop)
			valid_q <= head.valid;
		else
			valid_q <= valid_n;
	end

	always_ff @(posedge clk) begin
		if (pop)
			rec_q <= head.rec;
	end

endmodule

/* src/whole_word_substring_count.sv */
// ----------------------------------------------------------------------------
// whole_word_substring_count
// case-insensitive, optionally whole-word, substring counter on a byte stream
// ----------------------------------------------------------------------------
// usage
//   text enters on the s_ stream, one byte per transfer, s_tlast on the final
//   byte. the pattern, its length and the whole-word flag are written through
//   wr_en / wr_index / wr_data between texts.
//   each accepted match leaves as one m_ transfer with m_tuser low; the final
//   byte adds a summary transfer with m_tuser high (total count, first start).
//   one byte can cause up to three result transfers.
// timing
//   a byte is taken every cycle while the four-entry bundle queue has room;
//   bytes with no result leave nothing in the queue. the bundle of a byte
//   is written into the queue, then loaded into the back part's record
//   register, and only then is its first result valid; later results follow
//   one per cycle while m_tready is high. sustained rate is one byte per
//   cycle, limited only by the result stream taking one record per cycle.
//   in whole-word mode a match is reported when the byte after it arrives,
//   or with the final byte when it ends the text.
// reset and stall
//   reset clears the registers and the stream state; no clearing pass.
//   when m_tready is low the queue fills and then s_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module whole_word_substring_count #(
	parameter int PATTERN_MAX = wwsc_pkg::PATTERN_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [wwsc_pkg::IDX_W-1:0]  wr_index,
	input  logic [wwsc_pkg::REG_W-1:0]  wr_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // text_byte
	input  logic                        s_tlast,   // last_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [63:0]                 m_tdata,   // match_found, match_position, match_count
	output logic                        m_tuser    // is_summary
);

	logic              push, pop;
	wwsc_pkg::bundle_t bundle, head;
	wwsc_pkg::q_stat_t q_stat;

	wwsc_front #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_stat.full),
		.push     (push),
		.bundle   (bundle)
	);

	wwsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (bundle),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	wwsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_stat.empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// match records always carry a found flag and a nonzero count
	`ASSERT_ALWAYS(a_match_rec, clk, arst_n, (m_tvalid && !m_tuser) |-> (m_tdata[0] && m_tdata[63:33] != 31'd0), "match record without count")

	// a summary without matches reports zero position and count
	`ASSERT_ALWAYS(a_empty_summary, clk, arst_n, (m_tvalid && m_tuser && !m_tdata[0]) |-> (m_tdata[63:1] == 63'd0), "empty summary not zero")

	// queued bundles reach the output without a dead cycle
	`ASSERT_NEXT(a_back_load, clk, arst_n, (!m_tvalid && !q_stat.empty), m_tvalid, "queued bundle not loaded")

endmodule
